/* hdl/xor_rotate_random_interval_unit_assert.svh */
// assertion macros for the interval random generator
`ifndef XOR_ROTATE_RANDOM_INTERVAL_UNIT_ASSERT_SVH
`define XOR_ROTATE_RANDOM_INTERVAL_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked out of reset
`define XRRI_ASSERT_NOW(lbl, clk, rst, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define XRRI_ASSERT_NEXT(lbl, clk, rst, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (cons)) else $error(msg);

`else

`define XRRI_ASSERT_NOW(lbl, clk, rst, ant, cons, msg)
`define XRRI_ASSERT_NEXT(lbl, clk, rst, ant, cons, msg)

`endif

`endif

/* hdl/xrri_pkg.sv */
// shared widths and seed mixing function of the interval random generator
package xrri_pkg;

  localparam int WordW = 16;
  localparam int CntW  = $clog2(WordW + 1);

  typedef logic [WordW-1:0] word_t;

  function automatic word_t rotl(input word_t v, input int unsigned n);
    word_t r;
    r = (v << n) | (v >> (WordW - n));
    return r;
  endfunction

  // two rotate steps that turn the seed into the next seed
  function automatic word_t mix_seed(input word_t seed, input word_t key);
    word_t a;
    word_t s;
    a = rotl(seed ^ key, 2);
    s = a + key;
    return rotl(s ^ seed, 3);
  endfunction

endpackage

/* hdl/xrri_divider.sv */
// bit-serial restoring remainder unit, one dividend bit per cycle
module xrri_divider
  import xrri_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  word_t dividend,
  input  word_t divisor,
  output logic  done,
  output word_t remainder
);

  word_t         quo;
  word_t         dvs;
  word_t         rem;
  logic [CntW-1:0] cnt;
  logic          busy;

  logic [WordW:0] trial;
  logic [WordW:0] diff;
  word_t          rem_next;

  // shift in the next dividend bit and subtract when it fits
  always_comb begin
    trial = {rem, quo[WordW-1]};
    diff  = trial - {1'b0, dvs};
    if (!diff[WordW]) begin
      rem_next = diff[WordW-1:0];
    end else begin
      rem_next = trial[WordW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CntW'(WordW);
        quo  <= dividend;
        dvs  <= divisor;
        rem  <= '0;
      end else if (busy) begin
        rem <= rem_next;
        quo <= quo << 1;
        cnt <= cnt - CntW'(1);
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign remainder = rem;

endmodule

/* hdl/xor_rotate_random_interval_unit.sv */
// Interval random generator: draws a 16-bit value in low_bound..high_bound.
// Input channel s_*: one beat per request. s_tuser is the request kind
// (0 draw, 1 load seed); s_tdata carries low_bound, high_bound, seed_value.
// Output channel m_*: one beat per request with the drawn number, 0 after
// a seed load, or low_bound-1 when the interval span wraps to zero.
// Config channel cfg_*: writes the mix_key word, always ready; write it only
// while no request is in flight.
// Flow: a draw mixes the seed and starts the bit-serial remainder unit on
// accept, waits in the divide state for the remainder, then hands the
// result over to the output register. Loads and zero-span draws skip the
// remainder unit. One request is worked on at a time: a new request is
// accepted only after the last one has reached the output register.
// The result sits in an output register, so a new request is accepted while
// the receiver stalls; a further result waits internally until the output
// register is taken, and input stays blocked meanwhile.
// Reset (rst, synchronous) clears seed and mix_key to zero and drops valid.
module xor_rotate_random_interval_unit
  import xrri_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,  // low_bound[15:0], high_bound[31:16], seed_value[47:32]
  input  logic        s_tuser,  // req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,  // number[15:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  `include "xor_rotate_random_interval_unit_assert.svh"

  typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_HOLD} state_t;

  state_t state;
  word_t  seed;
  word_t  key;
  word_t  lo_q;
  word_t  res;

  word_t  lo_in;
  word_t  hi_in;
  word_t  sv_in;
  word_t  span;
  word_t  x_new;
  word_t  mag;
  logic   accept;
  logic   div_start;
  logic   div_done;
  word_t  div_rem;
  logic   out_free;

  assign lo_in  = s_tdata[15:0];
  assign hi_in  = s_tdata[31:16];
  assign sv_in  = s_tdata[47:32];
  assign span   = hi_in - lo_in + 16'd1;
  assign x_new  = mix_seed(seed, key);
  // magnitude as signed, the most negative word maps onto itself
  assign mag    = x_new[WordW-1] ? (~x_new + 16'd1) : x_new;

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;
  assign div_start = accept && !s_tuser && (span != '0);
  assign out_free  = !m_tvalid || m_tready;

  xrri_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (mag),
    .divisor   (span),
    .done      (div_done),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      seed     <= '0;
      key      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        key <= cfg_data;
      end
      // in the hold state the output register is refilled instead
      if (m_tready && state != ST_HOLD) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (s_tuser) begin
              seed  <= sv_in;
              res   <= '0;
              state <= ST_HOLD;
            end else if (span == '0) begin
              res   <= lo_in - 16'd1;
              state <= ST_HOLD;
            end else begin
              seed  <= x_new;
              lo_q  <= lo_in;
              state <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          if (div_done) begin
            res   <= div_rem + lo_q;
            state <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= res;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `XRRI_ASSERT_NEXT(a_busy_after_accept, clk, rst, s_tvalid && s_tready, !s_tready,
                    "input still ready right after a request was taken")
  `XRRI_ASSERT_NOW(a_done_in_div, clk, rst, div_done, state == ST_DIV,
                   "remainder finished outside the divide state")
  `XRRI_ASSERT_NEXT(a_done_to_hold, clk, rst, div_done, state == ST_HOLD,
                    "remainder result not handed over")
  `XRRI_ASSERT_NEXT(a_hold_emits, clk, rst, state == ST_HOLD && out_free,
                    m_tvalid && m_tdata == $past(res),
                    "pending result not moved to the output register")

endmodule

/* dv/tb_top.sv */
// self-checking testbench of the interval random generator with seed load and mix key
module tb_top;
  import xrri_pkg::word_t;

  localparam bit REQ_DRAW = 1'b0;
  localparam bit REQ_LOAD = 1'b1;
  localparam int IDLE_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 30;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;   // low_bound[15:0], high_bound[31:16], seed_value[47:32]
  logic        s_tuser = 1'b0; // req_type
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;        // number[15:0]
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;

  word_t model_seed = '0;
  word_t model_key = '0;
  word_t expected_numbers[$];
  word_t want_number;
  int    errors = 0;
  int    idle_cycles = 0;
  int    sink_hold = 0;
  bit    source_gaps = 1'b0;
  bit    sink_stalls = 1'b0;

  xor_rotate_random_interval_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic word_t rotate_left(input word_t v, input int n);
    return (v << n) | (v >> (16 - n));
  endfunction

  function automatic word_t next_seed(input word_t seed, input word_t key);
    word_t a;
    word_t s;
    a = rotate_left(seed ^ key, 2);
    s = a + key;
    return rotate_left(s ^ seed, 3);
  endfunction

  // updates the shadow seed as the block does
  function automatic word_t predict_number(input bit kind, input word_t lo, input word_t hi,
                                           input word_t sv);
    word_t span;
    word_t x;
    logic [16:0] mag;
    logic [16:0] rem;
    if (kind == REQ_LOAD) begin
      model_seed = sv;
      return '0;
    end
    span = hi - lo + 16'd1;
    if (span == '0) return lo - 16'd1;
    x = next_seed(model_seed, model_key);
    model_seed = x;
    mag = x[15] ? (17'h10000 - {1'b0, x}) : {1'b0, x};
    rem = mag % {1'b0, span};
    return rem[15:0] + lo;
  endfunction

  function automatic int pick_gap();
    int r;
    if (!source_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // result side
  always @(posedge clk) begin
    if (sink_hold > 0) begin
      sink_hold--;
    end else if (!sink_stalls) begin
      m_tready <= 1'b1;
    end else if ($urandom_range(0, 99) < 60) begin
      m_tready <= 1'b1;
      sink_hold = $urandom_range(0, 6);
    end else begin
      m_tready <= 1'b0;
      sink_hold = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3) : $urandom_range(20, 60);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_numbers.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, expected none, actual %h", $time, m_tdata);
      end else begin
        want_number = expected_numbers.pop_front();
        if (m_tdata !== want_number) begin
          errors++;
          $display("%0t: number mismatch, expected %h, actual %h", $time, want_number, m_tdata);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_request(input bit kind, input word_t lo, input word_t hi, input word_t sv);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {sv, hi, lo};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_numbers.push_back(predict_number(kind, lo, hi, sv));
  endtask

  task automatic draw(input word_t lo, input word_t hi);
    send_request(REQ_DRAW, lo, hi, word_t'($urandom));
  endtask

  task automatic load_seed(input word_t sv);
    send_request(REQ_LOAD, word_t'($urandom), word_t'($urandom), sv);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (expected_numbers.size() != 0) @(posedge clk);
  endtask

  task automatic write_mix_key(input word_t key);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= key;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    model_key = key;
    cfg_valid <= 1'b0;
  endtask

  task automatic random_request();
    int r;
    word_t lo;
    r = $urandom_range(0, 99);
    lo = word_t'($urandom);
    if (r < 14)      load_seed(word_t'($urandom));
    else if (r < 20) draw(lo, lo - 16'd1);
    else if (r < 45) draw(lo, lo + word_t'($urandom_range(0, 15)));
    else if (r < 60) draw(lo, lo + word_t'($urandom_range(32767, 65534)));
    else if (r < 65) draw(lo, lo);
    else             draw(lo, word_t'($urandom));
  endtask

  task automatic test_reset_state();
    // seed and key are zero, so the first draw mixes to zero
    draw(16'h0000, 16'h0000);
    draw(16'h0000, 16'h0009);
  endtask

  task automatic test_zero_span();
    // seed must stay put across these
    draw(16'h0000, 16'hFFFF);
    draw(16'h0005, 16'h0004);
    draw(16'hFFFF, 16'hFFFE);
  endtask

  task automatic test_bound_extremes();
    load_seed(16'h1234);
    draw(16'h0000, 16'hFFFE);
    draw(16'hFFFF, 16'hFFFF);
    draw(16'h0001, 16'hFFFF);
  endtask

  task automatic test_reversed_bounds();
    draw(16'hFFF0, 16'h000F);
    draw(16'h8000, 16'h0000);
    draw(16'hFFFF, 16'h7FFE);
  endtask

  task automatic test_seed_load();
    write_mix_key(16'hFFFF);
    load_seed(16'hFFFF);
    draw(16'h0100, 16'h01FF);
    load_seed(16'h0000);
    draw(16'h0000, 16'h7FFF);
  endtask

  // find a seed that mixes to the most negative word, so the magnitude is 32768
  task automatic test_most_negative();
    int found;
    int k;
    int s;
    found = -1;
    for (k = 1; k <= 64 && found < 0; k++) begin
      for (s = 0; s < 65536 && found < 0; s++) begin
        if (next_seed(word_t'(s), word_t'(k)) == 16'h8000) found = s;
      end
    end
    if (found >= 0) begin
      write_mix_key(word_t'(k - 1));
      load_seed(word_t'(found));
      draw(16'h0000, 16'hFFFE);
      load_seed(word_t'(found));
      draw(16'h0000, 16'h7FFF);
      load_seed(word_t'(found));
      draw(16'h0010, 16'h8010);
    end
  endtask

  task automatic test_random_traffic();
    word_t keys[6];
    int p;
    int n;
    keys = '{16'h0000, 16'hFFFF, 16'h8000, 16'h0001, word_t'($urandom), word_t'($urandom)};
    for (p = 0; p < 6; p++) begin
      write_mix_key(keys[p]);
      source_gaps = (p != 2);
      sink_stalls = (p != 3);
      for (n = 0; n < 240; n++) random_request();
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_zero_span();
    test_bound_extremes();
    source_gaps = 1'b1;
    sink_stalls = 1'b1;
    test_reversed_bounds();
    test_seed_load();
    test_most_negative();
    test_random_traffic();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
